// File: hdl/p2plrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package p2plrc_pkg;

  localparam int BYTE_W           = 8;
  localparam int SLOTS            = 255;
  localparam int MAX_PACKET_BYTES = 64;
  localparam int ID_COPIES        = 3;
  localparam int NUMBER_COPIES    = 3;
  localparam int END_BYTES        = 6;
  localparam int END_ZERO_MIN     = 5;
  localparam int HEADER_BYTES     = 6;
  localparam int REQUEST_BYTES    = 6;
  localparam int ACK_BYTES        = 6;
  localparam int ID_BYTES         = 3;
  localparam logic [7:0] LAST_NUMBER  = 8'hFF;
  localparam logic [7:0] FIRST_NUMBER = 8'h01;

  localparam logic [1:0] CFG_PEER_ID      = 2'd0;
  localparam logic [1:0] CFG_OWN_ID       = 2'd1;
  localparam logic [1:0] CFG_PACKET_BYTES = 2'd2;

  typedef enum logic [2:0] {
    RX_IDLE,
    RX_ID,
    RX_NUMBER,
    RX_DATA,
    RX_END
  } rx_phase_t;

  typedef enum logic [1:0] {
    TX_HEADER,
    TX_REQUEST,
    TX_CHECK,
    TX_ACK
  } tx_phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_COPY
  } ctl_state_t;

endpackage
`default_nettype wire

// File: hdl/p2p_link_receiver_control.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_func, in_rx_byte
// out_      output     out_valid/out_ready  out_ctrl_byte, out_data_byte, out_data_active
// cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A received byte is handled in ST_IDLE; a tick also passes through ST_TICK (one store read).
// A good packet's bytes are copied from staging memory to the store, one byte a cycle,
// before the next transfer is taken.
// Reset clears all control state and the slot map at once; the store needs no clearing pass.
// A tick is taken only while the output register is free or draining this cycle.
module p2p_link_receiver_control #(
  parameter int MAX_PACKET_BYTES = p2plrc_pkg::MAX_PACKET_BYTES
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_func,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] out_ctrl_byte,
  output logic      [7:0] out_data_byte,
  output logic            out_data_active,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int SLOTS = p2plrc_pkg::SLOTS;
  localparam int DEPTH = SLOTS * MAX_PACKET_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(MAX_PACKET_BYTES + 2);
  localparam int SW    = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;

  logic [7:0] peer_id_r, own_id_r;
  logic [6:0] pkt_bytes_r;

  p2plrc_pkg::rx_phase_t rx_phase_r, rx_phase_nxt;
  logic [1:0] id_seen_r, id_seen_nxt, id_match_r, id_match_nxt, num_pos_r, num_pos_nxt;
  logic [7:0] num_copy0_r, num_copy0_nxt, num_copy1_r, num_copy1_nxt, cur_num_r, cur_num_nxt;
  logic [PW-1:0] pay_pos_r, pay_pos_nxt;
  logic [2:0] end_seen_r, end_seen_nxt, end_zero_r, end_zero_nxt;

  p2plrc_pkg::tx_phase_t tx_phase_r, tx_phase_nxt;
  logic [2:0] hdr_pos_r, hdr_pos_nxt, req_pos_r, req_pos_nxt, ack_pos_r, ack_pos_nxt;
  logic [7:0] scan_slot_r, scan_slot_nxt, session_r, session_nxt, next_dlv_r, next_dlv_nxt;
  logic [PW-1:0] dlv_pos_r, dlv_pos_nxt;
  logic sess_req_r, sess_req_nxt, got_pkt_r, got_pkt_nxt;
  logic delivering_r, delivering_nxt, wrapped_r, wrapped_nxt;
  logic [SLOTS-1:0] slot_filled_r, slot_filled_nxt;

  p2plrc_pkg::ctl_state_t st_r, st_nxt;
  logic [PW-1:0] copy_k_r, copy_k_nxt, copy_n_r, copy_n_nxt, copy_wr_k_r;
  logic [7:0] copy_slot_r, copy_slot_nxt;
  logic copy_wr_v_r, copy_issue;
  logic commit_go;

  logic tick_mem_r, tick_mem_nxt, tick_active_r, tick_active_nxt;
  logic [7:0] tick_data_r, tick_data_nxt, tick_ctrl_r, tick_ctrl_nxt;
  logic [AW-1:0] dlv_addr, st_wr_addr;
  logic [7:0] st_rd_data;

  logic [7:0] stg_mem [MAX_PACKET_BYTES];
  logic [7:0] stg_rd_r;
  logic stg_we;

  logic out_valid_r, out_active_r;
  logic [7:0] out_ctrl_r, out_data_r;

  logic byte_acc, tick_acc;
  logic [PW-1:0] eff;

  assign byte_acc = in_valid && in_ready && !in_func;
  assign tick_acc = in_valid && in_ready && in_func;

  always_comb begin
    if (pkt_bytes_r == 7'd0) begin
      eff = PW'(1);
    end else if (int'(pkt_bytes_r) > MAX_PACKET_BYTES) begin
      eff = PW'(MAX_PACKET_BYTES);
    end else begin
      eff = PW'(pkt_bytes_r);
    end
  end

  always_comb begin
    logic [7:0] vote;
    logic       maj;
    logic [7:0] idx;
    logic [7:0] nd;
    rx_phase_nxt    = rx_phase_r;
    id_seen_nxt     = id_seen_r;
    id_match_nxt    = id_match_r;
    num_pos_nxt     = num_pos_r;
    num_copy0_nxt   = num_copy0_r;
    num_copy1_nxt   = num_copy1_r;
    cur_num_nxt     = cur_num_r;
    pay_pos_nxt     = pay_pos_r;
    end_seen_nxt    = end_seen_r;
    end_zero_nxt    = end_zero_r;
    tx_phase_nxt    = tx_phase_r;
    hdr_pos_nxt     = hdr_pos_r;
    req_pos_nxt     = req_pos_r;
    ack_pos_nxt     = ack_pos_r;
    scan_slot_nxt   = scan_slot_r;
    session_nxt     = session_r;
    next_dlv_nxt    = next_dlv_r;
    dlv_pos_nxt     = dlv_pos_r;
    sess_req_nxt    = sess_req_r;
    got_pkt_nxt     = got_pkt_r;
    delivering_nxt  = delivering_r;
    wrapped_nxt     = wrapped_r;
    slot_filled_nxt = slot_filled_r;
    copy_k_nxt      = copy_k_r;
    copy_n_nxt      = copy_n_r;
    copy_slot_nxt   = copy_slot_r;
    commit_go       = 1'b0;
    stg_we          = 1'b0;
    tick_mem_nxt    = 1'b0;
    tick_active_nxt = tick_active_r;
    tick_data_nxt   = tick_data_r;
    tick_ctrl_nxt   = tick_ctrl_r;
    dlv_addr        = '0;
    vote            = 8'd0;
    maj             = 1'b1;
    idx             = cur_num_r - 8'd1;
    nd              = 8'd0;

    if (byte_acc) begin
      case (rx_phase_r)
        p2plrc_pkg::RX_ID: begin
          id_match_nxt = id_match_r + ((in_rx_byte == peer_id_r) ? 2'd1 : 2'd0);
          id_seen_nxt  = id_seen_r + 2'd1;
          if (int'(id_seen_nxt) >= p2plrc_pkg::ID_COPIES) begin
            id_seen_nxt  = 2'd0;
            rx_phase_nxt = p2plrc_pkg::RX_IDLE;
            if (int'(id_match_nxt) == p2plrc_pkg::ID_COPIES) begin
              id_match_nxt = 2'd0;
              rx_phase_nxt = p2plrc_pkg::RX_NUMBER;
            end else if (in_rx_byte == peer_id_r) begin
              rx_phase_nxt = p2plrc_pkg::RX_ID;
              id_seen_nxt  = 2'd1;
              id_match_nxt = 2'd1;
            end else begin
              id_match_nxt = 2'd0;
            end
          end
        end
        p2plrc_pkg::RX_NUMBER: begin
          if (num_pos_r == 2'd0) begin
            num_copy0_nxt = in_rx_byte;
            num_pos_nxt   = 2'd1;
          end else if (num_pos_r == 2'd1) begin
            num_copy1_nxt = in_rx_byte;
            num_pos_nxt   = 2'd2;
          end else begin
            num_pos_nxt = 2'd0;
            if (num_copy0_r == num_copy1_r) begin
              vote = num_copy0_r;
            end else if (num_copy1_r == in_rx_byte) begin
              vote = num_copy1_r;
            end else if (in_rx_byte == num_copy0_r) begin
              vote = in_rx_byte;
            end else begin
              maj = 1'b0;
            end
            if (maj && sess_req_r && vote != 8'd0) begin
              cur_num_nxt  = vote;
              pay_pos_nxt  = '0;
              rx_phase_nxt = p2plrc_pkg::RX_DATA;
            end else begin
              rx_phase_nxt = p2plrc_pkg::RX_IDLE;
            end
          end
        end
        p2plrc_pkg::RX_DATA: begin
          stg_we      = int'(pay_pos_r) < MAX_PACKET_BYTES;
          pay_pos_nxt = pay_pos_r + PW'(1);
          if (pay_pos_nxt >= eff) begin
            pay_pos_nxt  = '0;
            rx_phase_nxt = p2plrc_pkg::RX_END;
          end
        end
        p2plrc_pkg::RX_END: begin
          end_zero_nxt = end_zero_r + ((in_rx_byte == 8'd0) ? 3'd1 : 3'd0);
          end_seen_nxt = end_seen_r + 3'd1;
          if (int'(end_seen_nxt) >= p2plrc_pkg::END_BYTES) begin
            if (int'(end_zero_nxt) >= p2plrc_pkg::END_ZERO_MIN && cur_num_r != 8'd0 &&
                int'(idx) < SLOTS && !slot_filled_r[idx]) begin
              commit_go            = 1'b1;
              got_pkt_nxt          = 1'b1;
              slot_filled_nxt[idx] = 1'b1;
              copy_k_nxt           = '0;
              copy_n_nxt           = eff;
              copy_slot_nxt        = idx;
            end
            end_seen_nxt = 3'd0;
            end_zero_nxt = 3'd0;
            rx_phase_nxt = p2plrc_pkg::RX_IDLE;
          end
        end
        default: begin
          rx_phase_nxt = p2plrc_pkg::RX_IDLE;
          if (in_rx_byte == peer_id_r) begin
            rx_phase_nxt = p2plrc_pkg::RX_ID;
            id_seen_nxt  = 2'd1;
            id_match_nxt = 2'd1;
          end
        end
      endcase
    end

    if (tick_acc) begin
      tick_active_nxt = delivering_r;
      tick_data_nxt   = 8'd0;
      if (delivering_r) begin
        if (dlv_pos_r == '0) begin
          tick_data_nxt = own_id_r;
          dlv_pos_nxt   = PW'(1);
        end else begin
          tick_mem_nxt = next_dlv_r != 8'd0 && int'(next_dlv_r) <= SLOTS &&
                         int'(dlv_pos_r) <= MAX_PACKET_BYTES;
          dlv_addr = AW'((int'(next_dlv_r) - 1) * MAX_PACKET_BYTES + int'(dlv_pos_r) - 1);
          dlv_pos_nxt = dlv_pos_r + PW'(1);
          if (dlv_pos_r >= eff) begin
            dlv_pos_nxt = '0;
            if (next_dlv_r == p2plrc_pkg::LAST_NUMBER) begin
              next_dlv_nxt = p2plrc_pkg::FIRST_NUMBER;
              wrapped_nxt  = 1'b1;
            end else begin
              next_dlv_nxt = next_dlv_r + 8'd1;
            end
            delivering_nxt = 1'b0;
          end
        end
      end

      tick_ctrl_nxt = 8'd0;
      case (tx_phase_r)
        p2plrc_pkg::TX_REQUEST: begin
          tick_ctrl_nxt = session_r;
          req_pos_nxt   = req_pos_r + 3'd1;
          if (int'(req_pos_nxt) >= p2plrc_pkg::REQUEST_BYTES) begin
            req_pos_nxt  = 3'd0;
            sess_req_nxt = 1'b1;
            if (got_pkt_r) begin
              tx_phase_nxt  = p2plrc_pkg::TX_CHECK;
              scan_slot_nxt = 8'd0;
            end else begin
              tx_phase_nxt = p2plrc_pkg::TX_HEADER;
            end
          end
        end
        p2plrc_pkg::TX_CHECK: begin
          if (wrapped_nxt) begin
            wrapped_nxt     = 1'b0;
            got_pkt_nxt     = 1'b0;
            sess_req_nxt    = 1'b0;
            tx_phase_nxt    = p2plrc_pkg::TX_HEADER;
            session_nxt     = (session_r == p2plrc_pkg::LAST_NUMBER) ?
                              p2plrc_pkg::FIRST_NUMBER : session_r + 8'd1;
            slot_filled_nxt = '0;
          end else begin
            nd = next_dlv_nxt - 8'd1;
            if (next_dlv_nxt != 8'd0 && int'(nd) < SLOTS && slot_filled_r[nd] &&
                !delivering_nxt) begin
              delivering_nxt = 1'b1;
            end
            if (int'(scan_slot_r) < SLOTS && slot_filled_r[scan_slot_r]) begin
              tx_phase_nxt = p2plrc_pkg::TX_ACK;
            end else begin
              scan_slot_nxt = (int'(scan_slot_r) + 1 >= SLOTS) ? 8'd0 : scan_slot_r + 8'd1;
            end
          end
        end
        p2plrc_pkg::TX_ACK: begin
          ack_pos_nxt = ack_pos_r + 3'd1;
          if (int'(ack_pos_r) < p2plrc_pkg::ID_BYTES) begin
            tick_ctrl_nxt = own_id_r;
          end else begin
            tick_ctrl_nxt = (int'(scan_slot_r) < SLOTS && slot_filled_r[scan_slot_r]) ?
                            scan_slot_r + 8'd1 : 8'd0;
            if (int'(ack_pos_nxt) >= p2plrc_pkg::ACK_BYTES) begin
              ack_pos_nxt   = 3'd0;
              scan_slot_nxt = (int'(scan_slot_r) + 1 >= SLOTS) ? 8'd0 : scan_slot_r + 8'd1;
              tx_phase_nxt  = p2plrc_pkg::TX_CHECK;
            end
          end
        end
        default: begin
          tick_ctrl_nxt = (int'(hdr_pos_r) < p2plrc_pkg::ID_BYTES) ? own_id_r : 8'd0;
          hdr_pos_nxt   = hdr_pos_r + 3'd1;
          if (int'(hdr_pos_nxt) >= p2plrc_pkg::HEADER_BYTES) begin
            hdr_pos_nxt  = 3'd0;
            tx_phase_nxt = p2plrc_pkg::TX_REQUEST;
          end
        end
      endcase
    end

    if (st_r == p2plrc_pkg::ST_COPY && copy_k_r < copy_n_r) begin
      copy_k_nxt = copy_k_r + PW'(1);
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      p2plrc_pkg::ST_IDLE: begin
        if (commit_go) begin
          st_nxt = p2plrc_pkg::ST_COPY;
        end else if (tick_acc) begin
          st_nxt = p2plrc_pkg::ST_TICK;
        end
      end
      p2plrc_pkg::ST_TICK: begin
        st_nxt = p2plrc_pkg::ST_IDLE;
      end
      p2plrc_pkg::ST_COPY: begin
        if (copy_k_r >= copy_n_r) begin
          st_nxt = p2plrc_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt = p2plrc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = (st_r == p2plrc_pkg::ST_IDLE) && (!in_func || !out_valid_r || out_ready);
    cfg_ready  = 1'b1;
    copy_issue = (st_r == p2plrc_pkg::ST_COPY) && (copy_k_r < copy_n_r);
    st_wr_addr = AW'(int'(copy_slot_r) * MAX_PACKET_BYTES + int'(copy_wr_k_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peer_id_r   <= 8'd1;
      own_id_r    <= 8'd2;
      pkt_bytes_r <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        p2plrc_pkg::CFG_PEER_ID:      peer_id_r   <= cfg_data;
        p2plrc_pkg::CFG_OWN_ID:       own_id_r    <= cfg_data;
        p2plrc_pkg::CFG_PACKET_BYTES: pkt_bytes_r <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_phase_r    <= p2plrc_pkg::RX_IDLE;
      id_seen_r     <= 2'd0;
      id_match_r    <= 2'd0;
      num_pos_r     <= 2'd0;
      cur_num_r     <= 8'd0;
      pay_pos_r     <= '0;
      end_seen_r    <= 3'd0;
      end_zero_r    <= 3'd0;
      tx_phase_r    <= p2plrc_pkg::TX_HEADER;
      hdr_pos_r     <= 3'd0;
      req_pos_r     <= 3'd0;
      ack_pos_r     <= 3'd0;
      scan_slot_r   <= 8'd0;
      session_r     <= p2plrc_pkg::FIRST_NUMBER;
      next_dlv_r    <= p2plrc_pkg::FIRST_NUMBER;
      dlv_pos_r     <= '0;
      sess_req_r    <= 1'b0;
      got_pkt_r     <= 1'b0;
      delivering_r  <= 1'b0;
      wrapped_r     <= 1'b0;
      slot_filled_r <= '0;
      st_r          <= p2plrc_pkg::ST_IDLE;
      copy_k_r      <= '0;
      copy_n_r      <= '0;
      copy_wr_v_r   <= 1'b0;
      tick_mem_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      rx_phase_r    <= rx_phase_nxt;
      id_seen_r     <= id_seen_nxt;
      id_match_r    <= id_match_nxt;
      num_pos_r     <= num_pos_nxt;
      cur_num_r     <= cur_num_nxt;
      pay_pos_r     <= pay_pos_nxt;
      end_seen_r    <= end_seen_nxt;
      end_zero_r    <= end_zero_nxt;
      tx_phase_r    <= tx_phase_nxt;
      hdr_pos_r     <= hdr_pos_nxt;
      req_pos_r     <= req_pos_nxt;
      ack_pos_r     <= ack_pos_nxt;
      scan_slot_r   <= scan_slot_nxt;
      session_r     <= session_nxt;
      next_dlv_r    <= next_dlv_nxt;
      dlv_pos_r     <= dlv_pos_nxt;
      sess_req_r    <= sess_req_nxt;
      got_pkt_r     <= got_pkt_nxt;
      delivering_r  <= delivering_nxt;
      wrapped_r     <= wrapped_nxt;
      slot_filled_r <= slot_filled_nxt;
      st_r          <= st_nxt;
      copy_k_r      <= copy_k_nxt;
      copy_n_r      <= copy_n_nxt;
      copy_wr_v_r   <= copy_issue;
      if (tick_acc) begin
        tick_mem_r <= tick_mem_nxt;
      end
      if (st_r == p2plrc_pkg::ST_TICK) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_copy0_r   <= num_copy0_nxt;
    num_copy1_r   <= num_copy1_nxt;
    copy_slot_r   <= copy_slot_nxt;
    copy_wr_k_r   <= copy_k_r;
    tick_active_r <= tick_active_nxt;
    tick_data_r   <= tick_data_nxt;
    tick_ctrl_r   <= tick_ctrl_nxt;
    if (st_r == p2plrc_pkg::ST_TICK) begin
      out_ctrl_r   <= tick_ctrl_r;
      out_data_r   <= tick_mem_r ? st_rd_data : tick_data_r;
      out_active_r <= tick_active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_we) begin
      stg_mem[pay_pos_r[SW-1:0]] <= in_rx_byte;
    end
    if (copy_issue) begin
      stg_rd_r <= stg_mem[copy_k_r[SW-1:0]];
    end
  end

  p2plrc_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (copy_wr_v_r),
    .wr_addr (st_wr_addr),
    .wr_data (stg_rd_r),
    .rd_en   (tick_acc && tick_mem_nxt),
    .rd_addr (dlv_addr),
    .rd_data (st_rd_data)
  );

  assign out_valid       = out_valid_r;
  assign out_ctrl_byte   = out_ctrl_r;
  assign out_data_byte   = out_data_r;
  assign out_data_active = out_active_r;

  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> ##1 out_valid_r)
    else $error("tick transfer without result");

  a_copy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    copy_wr_v_r |-> !in_ready)
    else $error("transfer taken during store copy");

  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == p2plrc_pkg::ST_COPY) |-> (copy_k_r <= copy_n_r))
    else $error("copy ran past packet size");

  a_dlv_number: assert property (@(posedge clk) disable iff (!rst_n)
    delivering_r |-> (next_dlv_r != 8'd0))
    else $error("delivery slot number zero");

endmodule
`default_nettype wire

// File: hdl/p2plrc_store.sv
`timescale 1ns / 1ps
`default_nettype none
module p2plrc_store #(
  parameter int DEPTH = p2plrc_pkg::SLOTS * p2plrc_pkg::MAX_PACKET_BYTES,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [AW-1:0]                 wr_addr,
  input  wire logic [p2plrc_pkg::BYTE_W-1:0] wr_data,
  input  wire logic                          rd_en,
  input  wire logic [AW-1:0]                 rd_addr,
  output logic      [p2plrc_pkg::BYTE_W-1:0] rd_data
);

  logic [p2plrc_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int STALL_LIMIT  = 20000;
  localparam int SETTLE_TICKS = 100;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_func;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_ctrl_byte;
  logic [7:0] out_data_byte;
  logic       out_data_active;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  typedef struct packed {
    logic [7:0] ctrl;
    logic [7:0] data;
    logic       active;
  } link_out_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_ID_COPY,
    FLAW_NUMBER_COPY,
    FLAW_NO_MAJORITY,
    FLAW_END_ONE,
    FLAW_END_TWO
  } flaw_t;

  link_out_t pending_out_q[$];
  int        fail_count;
  int        src_idle_pct;
  int        sink_stall_pct;
  int        sink_hold_cycles;
  int        items_sent;
  int        quiet_cycles;
  logic [7:0] next_tx_number;

  // expected receiver state
  logic [7:0] m_peer_id;
  logic [7:0] m_own_id;
  logic [6:0] m_pkt_bytes;
  p2plrc_pkg::rx_phase_t m_rx;
  int         m_id_seen;
  int         m_id_match;
  int         m_num_pos;
  logic [7:0] m_num_copy [3];
  logic [7:0] m_cur_num;
  int         m_pay_pos;
  logic [7:0] m_staging [p2plrc_pkg::MAX_PACKET_BYTES];
  int         m_end_seen;
  int         m_end_zero;
  bit         m_filled [p2plrc_pkg::SLOTS];
  logic [7:0] m_store [p2plrc_pkg::SLOTS*p2plrc_pkg::MAX_PACKET_BYTES];
  p2plrc_pkg::tx_phase_t m_tx;
  int         m_hdr_pos;
  int         m_req_pos;
  int         m_ack_pos;
  int         m_scan;
  logic [7:0] m_session;
  logic [7:0] m_next_num;
  int         m_dpos;
  bit         m_requested;
  bit         m_got_pkt;
  bit         m_delivering;
  bit         m_wrapped;

  p2p_link_receiver_control DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ctrl_byte  (out_ctrl_byte),
    .out_data_byte  (out_data_byte),
    .out_data_active(out_data_active),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int payload_len();
    if (m_pkt_bytes == 0) return 1;
    if (int'(m_pkt_bytes) > p2plrc_pkg::MAX_PACKET_BYTES) return p2plrc_pkg::MAX_PACKET_BYTES;
    return int'(m_pkt_bytes);
  endfunction

  function automatic void clear_model();
    m_peer_id = 8'd1;
    m_own_id = 8'd2;
    m_pkt_bytes = 7'd64;
    m_rx = p2plrc_pkg::RX_IDLE;
    m_id_seen = 0;
    m_id_match = 0;
    m_num_pos = 0;
    foreach (m_num_copy[i]) m_num_copy[i] = 8'd0;
    m_cur_num = 8'd0;
    m_pay_pos = 0;
    m_end_seen = 0;
    m_end_zero = 0;
    foreach (m_filled[i]) m_filled[i] = 1'b0;
    m_tx = p2plrc_pkg::TX_HEADER;
    m_hdr_pos = 0;
    m_req_pos = 0;
    m_ack_pos = 0;
    m_scan = 0;
    m_session = p2plrc_pkg::FIRST_NUMBER;
    m_next_num = p2plrc_pkg::FIRST_NUMBER;
    m_dpos = 0;
    m_requested = 1'b0;
    m_got_pkt = 1'b0;
    m_delivering = 1'b0;
    m_wrapped = 1'b0;
  endfunction

  function automatic void start_on_id(logic [7:0] b);
    if (b == m_peer_id) begin
      m_rx = p2plrc_pkg::RX_ID;
      m_id_seen = 1;
      m_id_match = 1;
    end
  endfunction

  function automatic void store_packet();
    int idx;
    idx = int'(m_cur_num) - 1;
    if (m_cur_num == 0 || idx >= p2plrc_pkg::SLOTS || m_filled[idx]) return;
    m_got_pkt = 1'b1;
    m_filled[idx] = 1'b1;
    for (int k = 0; k < payload_len(); k++)
      m_store[idx*p2plrc_pkg::MAX_PACKET_BYTES + k] = m_staging[k];
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] v;
    bit         maj;
    bit         ok;
    case (m_rx)
      p2plrc_pkg::RX_ID: begin
        if (b == m_peer_id) m_id_match++;
        m_id_seen++;
        if (m_id_seen >= p2plrc_pkg::ID_COPIES) begin
          ok = (m_id_match == p2plrc_pkg::ID_COPIES);
          m_id_seen = 0;
          m_id_match = 0;
          m_rx = p2plrc_pkg::RX_IDLE;
          if (ok) m_rx = p2plrc_pkg::RX_NUMBER;
          else start_on_id(b);
        end
      end
      p2plrc_pkg::RX_NUMBER: begin
        m_num_copy[m_num_pos > 2 ? 2 : m_num_pos] = b;
        m_num_pos++;
        if (m_num_pos >= p2plrc_pkg::NUMBER_COPIES) begin
          m_num_pos = 0;
          maj = 1'b1;
          v = 8'd0;
          if (m_num_copy[0] == m_num_copy[1]) v = m_num_copy[0];
          else if (m_num_copy[1] == m_num_copy[2]) v = m_num_copy[1];
          else if (m_num_copy[2] == m_num_copy[0]) v = m_num_copy[2];
          else maj = 1'b0;
          if (maj && m_requested && v != 0) begin
            m_cur_num = v;
            m_pay_pos = 0;
            m_rx = p2plrc_pkg::RX_DATA;
          end else begin
            m_rx = p2plrc_pkg::RX_IDLE;
          end
        end
      end
      p2plrc_pkg::RX_DATA: begin
        if (m_pay_pos < p2plrc_pkg::MAX_PACKET_BYTES) m_staging[m_pay_pos] = b;
        m_pay_pos++;
        if (m_pay_pos >= payload_len()) begin
          m_pay_pos = 0;
          m_rx = p2plrc_pkg::RX_END;
        end
      end
      p2plrc_pkg::RX_END: begin
        if (b == 0) m_end_zero++;
        m_end_seen++;
        if (m_end_seen >= p2plrc_pkg::END_BYTES) begin
          if (m_end_zero >= p2plrc_pkg::END_ZERO_MIN) store_packet();
          m_end_seen = 0;
          m_end_zero = 0;
          m_rx = p2plrc_pkg::RX_IDLE;
        end
      end
      default: begin
        m_rx = p2plrc_pkg::RX_IDLE;
        start_on_id(b);
      end
    endcase
  endfunction

  function automatic void deliver_byte(output logic [7:0] d, output logic active);
    int slot;
    int off;
    d = 8'd0;
    active = m_delivering;
    if (!m_delivering) return;
    if (m_dpos == 0) begin
      d = m_own_id;
      m_dpos = 1;
    end else begin
      slot = int'(m_next_num) - 1;
      off = m_dpos - 1;
      if (m_next_num != 0 && slot < p2plrc_pkg::SLOTS && off < p2plrc_pkg::MAX_PACKET_BYTES)
        d = m_store[slot*p2plrc_pkg::MAX_PACKET_BYTES + off];
      m_dpos++;
      if (m_dpos >= payload_len() + 1) begin
        m_dpos = 0;
        if (m_next_num == p2plrc_pkg::LAST_NUMBER) begin
          m_next_num = p2plrc_pkg::FIRST_NUMBER;
          m_wrapped = 1'b1;
        end else begin
          m_next_num++;
        end
        m_delivering = 1'b0;
      end
    end
  endfunction

  function automatic logic [7:0] control_byte();
    logic [7:0] c;
    int         nd;
    c = 8'd0;
    case (m_tx)
      p2plrc_pkg::TX_REQUEST: begin
        c = m_session;
        m_req_pos++;
        if (m_req_pos >= p2plrc_pkg::REQUEST_BYTES) begin
          m_req_pos = 0;
          m_requested = 1'b1;
          if (m_got_pkt) begin
            m_tx = p2plrc_pkg::TX_CHECK;
            m_scan = 0;
          end else begin
            m_tx = p2plrc_pkg::TX_HEADER;
          end
        end
      end
      p2plrc_pkg::TX_CHECK: begin
        nd = int'(m_next_num) - 1;
        if (m_wrapped) begin
          m_wrapped = 1'b0;
          m_got_pkt = 1'b0;
          m_requested = 1'b0;
          m_tx = p2plrc_pkg::TX_HEADER;
          m_session = (m_session == p2plrc_pkg::LAST_NUMBER) ? p2plrc_pkg::FIRST_NUMBER :
                      m_session + 8'd1;
          foreach (m_filled[i]) m_filled[i] = 1'b0;
        end else begin
          if (m_next_num != 0 && nd < p2plrc_pkg::SLOTS && m_filled[nd] && !m_delivering)
            m_delivering = 1'b1;
          if (m_scan < p2plrc_pkg::SLOTS && m_filled[m_scan]) begin
            m_tx = p2plrc_pkg::TX_ACK;
          end else begin
            m_scan++;
            if (m_scan >= p2plrc_pkg::SLOTS) m_scan = 0;
          end
        end
      end
      p2plrc_pkg::TX_ACK: begin
        if (m_ack_pos < p2plrc_pkg::ID_BYTES) begin
          c = m_own_id;
          m_ack_pos++;
        end else begin
          c = (m_scan < p2plrc_pkg::SLOTS && m_filled[m_scan]) ? 8'(m_scan + 1) : 8'd0;
          m_ack_pos++;
          if (m_ack_pos >= p2plrc_pkg::ACK_BYTES) begin
            m_ack_pos = 0;
            m_scan++;
            if (m_scan >= p2plrc_pkg::SLOTS) m_scan = 0;
            m_tx = p2plrc_pkg::TX_CHECK;
          end
        end
      end
      default: begin
        c = (m_hdr_pos < p2plrc_pkg::ID_BYTES) ? m_own_id : 8'd0;
        m_hdr_pos++;
        if (m_hdr_pos >= p2plrc_pkg::HEADER_BYTES) begin
          m_hdr_pos = 0;
          m_tx = p2plrc_pkg::TX_REQUEST;
        end
      end
    endcase
    return c;
  endfunction

  function automatic void predict_item(logic func, logic [7:0] b);
    link_out_t r;
    if (!func) begin
      if (m_rx == p2plrc_pkg::RX_IDLE) start_on_id(b);
      else deframe_byte(b);
    end else begin
      deliver_byte(r.data, r.active);
      r.ctrl = control_byte();
      pending_out_q.push_back(r);
    end
  endfunction

  // a larger size must not reach a stored packet that was written shorter
  function automatic bit can_grow();
    if (m_rx == p2plrc_pkg::RX_END || m_delivering) return 1'b0;
    for (int i = int'(m_next_num) - 1; i < p2plrc_pkg::SLOTS; i++)
      if (i >= 0 && m_filled[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_item(logic func, logic [7:0] b);
    @(negedge clk);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    predict_item(func, b);
    items_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_out_q.size() != 0) @(posedge clk);
    repeat (2 * p2plrc_pkg::MAX_PACKET_BYTES + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      p2plrc_pkg::CFG_PEER_ID:      m_peer_id = val;
      p2plrc_pkg::CFG_OWN_ID:       m_own_id = val;
      p2plrc_pkg::CFG_PACKET_BYTES: m_pkt_bytes = val[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_link(logic [7:0] peer, logic [7:0] own, int bytes);
    wait_drained();
    if (bytes > payload_len() && !can_grow()) bytes = payload_len();
    write_reg(p2plrc_pkg::CFG_PEER_ID, peer);
    write_reg(p2plrc_pkg::CFG_OWN_ID, own);
    write_reg(p2plrc_pkg::CFG_PACKET_BYTES, 8'(bytes));
  endtask

  task automatic send_frame(logic [7:0] num, flaw_t flaw);
    int bad_pos;
    bad_pos = $urandom_range(2);
    for (int i = 0; i < p2plrc_pkg::ID_COPIES; i++)
      send_item(1'b0, (flaw == FLAW_ID_COPY && i == bad_pos) ?
                m_peer_id ^ 8'($urandom_range(1, 255)) : m_peer_id);
    for (int i = 0; i < p2plrc_pkg::NUMBER_COPIES; i++) begin
      if ((flaw == FLAW_NUMBER_COPY && i == bad_pos) || (flaw == FLAW_NO_MAJORITY && i != 0))
        send_item(1'b0, num ^ 8'(i * 37 + 1));
      else
        send_item(1'b0, num);
    end
    for (int i = 0; i < payload_len(); i++) send_item(1'b0, 8'($urandom_range(255)));
    for (int i = 0; i < p2plrc_pkg::END_BYTES; i++) begin
      if ((flaw == FLAW_END_ONE && i == bad_pos) || (flaw == FLAW_END_TWO && i <= 1))
        send_item(1'b0, 8'($urandom_range(1, 255)));
      else
        send_item(1'b0, 8'd0);
    end
  endtask

  task automatic test_frame_before_request();
    send_frame(8'd1, FLAW_NONE);
    send_ticks(14);
  endtask

  task automatic test_directed();
    send_ticks(12);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h07);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h03);
    send_item(1'b0, 8'h05);
    send_item(1'b0, 8'h09);
    send_frame(8'h00, FLAW_NONE);
    send_frame(8'h01, FLAW_END_ONE);
    send_frame(8'h02, FLAW_END_TWO);
    send_frame(8'hFF, FLAW_NUMBER_COPY);
    send_ticks(20);
  endtask

  task automatic test_random(int n);
    int r;
    flaw_t flaw;
    logic [7:0] num;
    items_sent = 0;
    while (items_sent < n) begin
      r = $urandom_range(99);
      if (r < 60) begin
        flaw = ($urandom_range(9) < 7) ? FLAW_NONE : flaw_t'($urandom_range(1, 5));
        if ($urandom_range(9) == 0) begin
          num = 8'($urandom_range(255));
        end else begin
          num = next_tx_number;
          next_tx_number = (next_tx_number == p2plrc_pkg::LAST_NUMBER) ?
                           p2plrc_pkg::FIRST_NUMBER : next_tx_number + 8'd1;
        end
        send_frame(num, flaw);
      end else if (r < 88) begin
        send_ticks($urandom_range(1, 10));
      end else begin
        send_item(1'b0, 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    sink_hold_cycles = 400;
    send_ticks(40);
  endtask

  always begin
    @(posedge clk);
    if (out_valid && out_ready) begin
      if (pending_out_q.size() == 0) begin
        $display("%0t: unexpected result ctrl %h data %h active %b", $time,
                 out_ctrl_byte, out_data_byte, out_data_active);
        fail_count++;
      end else begin
        link_out_t want;
        want = pending_out_q.pop_front();
        if (out_ctrl_byte !== want.ctrl) begin
          $display("%0t: ctrl_byte expected %h actual %h", $time, want.ctrl, out_ctrl_byte);
          fail_count++;
        end
        if (out_data_byte !== want.data) begin
          $display("%0t: data_byte expected %h actual %h", $time, want.data, out_data_byte);
          fail_count++;
        end
        if (out_data_active !== want.active) begin
          $display("%0t: data_active expected %b actual %b", $time, want.active,
                   out_data_active);
          fail_count++;
        end
      end
    end
    @(negedge clk);
    if (sink_hold_cycles > 0) begin
      out_ready <= 1'b0;
      sink_hold_cycles--;
    end else if (sink_stall_pct > 0) begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** p2p_link_receiver_control: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = 1'b0;
    in_rx_byte = 8'd0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = p2plrc_pkg::CFG_PEER_ID;
    cfg_data = 8'd0;
    fail_count = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    sink_hold_cycles = 0;
    items_sent = 0;
    next_tx_number = p2plrc_pkg::FIRST_NUMBER;
    clear_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_frame_before_request();
    set_link(8'hFF, 8'hFF, 1);
    test_directed();

    set_link(8'd1, 8'd1, p2plrc_pkg::MAX_PACKET_BYTES);
    test_random(250);

    set_link(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), $urandom_range(1, 8));
    src_idle_pct = 51;
    test_random(250);

    set_link(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), $urandom_range(1, 8));
    src_idle_pct = 0;
    sink_stall_pct = 51;
    test_random(250);

    set_link(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), $urandom_range(1, 4));
    src_idle_pct = 18;
    sink_stall_pct = 18;
    test_random(250);

    test_backpressure();

    wait_drained();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (fail_count == 0 && pending_out_q.size() == 0)
      $display("** p2p_link_receiver_control: PASSED **");
    else
      $display("** p2p_link_receiver_control: FAILED **");
    $finish;
  end

endmodule
